FILE: rtl/lane_dispatch_starvation_arbiter_core_macros.svh
// Assertion macros shared by the lane dispatch arbiter RTL.
`ifndef LANE_DISPATCH_STARVATION_ARBITER_CORE_MACROS_SVH
`define LANE_DISPATCH_STARVATION_ARBITER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked assertion, disabled while reset is asserted (active low).
`define LDSA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("ldsa assertion failed");
// Clocked assertion that also holds during reset.
`define LDSA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ldsa assertion failed");
`else
`define LDSA_ASSERT(lbl, clk, rstn, prop)
`define LDSA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/ldsa_pkg.sv
package ldsa_pkg;

    // Lane codes of the grant result.
    localparam logic [2:0] LANE_INTERACTIVE = 3'd0;
    localparam logic [2:0] LANE_BOOST       = 3'd1;
    localparam logic [2:0] LANE_NORMAL      = 3'd2;
    localparam logic [2:0] LANE_COMPUTE     = 3'd3;
    localparam logic [2:0] LANE_BACKGROUND  = 3'd4;
    localparam logic [2:0] LANE_NONE        = 3'd5;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTAINED_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_LIMIT    = 2'd2;

    // All limit registers are eight bits wide.
    localparam int unsigned LIMIT_W = 8;
    localparam logic [LIMIT_W-1:0] BURST_LIMIT_RST     = 8'd8;
    localparam logic [LIMIT_W-1:0] CONTAINED_LIMIT_RST = 8'd4;
    localparam logic [LIMIT_W-1:0] SHARED_LIMIT_RST    = 8'd4;

    // One dispatch request: the not-empty flags of the five lanes.
    typedef struct packed {
        logic interactive_ready;
        logic boost_ready;
        logic normal_ready;
        logic compute_ready;
        logic background_ready;
    } t_req;

    // One grant result.
    typedef struct packed {
        logic [2:0] granted_lane;
        logic       forced_grant;
    } t_grant;

    // Register limits handed to the grant logic.
    typedef struct packed {
        logic [LIMIT_W-1:0] burst_limit;
        logic [LIMIT_W-1:0] contained_limit;
        logic [LIMIT_W-1:0] shared_limit;
    } t_limits;

endpackage

FILE: rtl/ldsa_grant.sv
module ldsa_grant
    import ldsa_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  t_req                   i_req,
    input  t_limits                i_limits,
    input  logic [COUNT_WIDTH-1:0] i_burst,
    input  logic [COUNT_WIDTH-1:0] i_contained,
    input  logic [COUNT_WIDTH-1:0] i_shared,
    output t_grant                 o_grant,
    output logic [COUNT_WIDTH-1:0] o_burst,
    output logic [COUNT_WIDTH-1:0] o_contained,
    output logic [COUNT_WIDTH-1:0] o_shared
);

    // Compare width covers both the counters and the eight-bit limits.
    localparam int unsigned CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [CMP_W-1:0]       burst_e, cont_e, shr_e;
    logic [CMP_W-1:0]       blim_e, clim_e, slim_e;
    logic                   burst_hit, bg_starved, norm_starved;
    logic [COUNT_WIDTH-1:0] burst_bump, cont_bump, shr_bump;
    logic                   is_high, is_low_norm, is_low_bg;

    assign burst_e = CMP_W'(i_burst);
    assign cont_e  = CMP_W'(i_contained);
    assign shr_e   = CMP_W'(i_shared);
    assign blim_e  = CMP_W'(i_limits.burst_limit);
    assign clim_e  = CMP_W'(i_limits.contained_limit);
    assign slim_e  = CMP_W'(i_limits.shared_limit);

    // Starvation and burst flags sampled before the grant.
    assign burst_hit    = burst_e >= blim_e;
    assign bg_starved   = cont_e >= clim_e;
    assign norm_starved = shr_e >= slim_e;

    // Saturating bumps: stop at the limit and at the counter's all-ones value.
    assign burst_bump = ((burst_e < blim_e) && (i_burst != '1))
                        ? i_burst + 1'b1 : i_burst;
    assign cont_bump  = ((cont_e < clim_e) && (i_contained != '1))
                        ? i_contained + 1'b1 : i_contained;
    assign shr_bump   = ((shr_e < slim_e) && (i_shared != '1))
                        ? i_shared + 1'b1 : i_shared;

    // Fixed priority chain with the starvation override ahead of normal.
    always_comb begin
        o_grant     = '{granted_lane: LANE_NONE, forced_grant: 1'b0};
        is_high     = 1'b0;
        is_low_norm = 1'b0;
        is_low_bg   = 1'b0;
        if (i_req.interactive_ready) begin
            o_grant.granted_lane = LANE_INTERACTIVE;
            is_high = 1'b1;
        end else if (i_req.boost_ready) begin
            o_grant.granted_lane = LANE_BOOST;
            is_high = 1'b1;
        end else if (burst_hit && norm_starved && i_req.normal_ready) begin
            o_grant.granted_lane = LANE_NORMAL;
            o_grant.forced_grant = 1'b1;
            is_low_norm = 1'b1;
        end else if (burst_hit && bg_starved && i_req.background_ready) begin
            o_grant.granted_lane = LANE_BACKGROUND;
            o_grant.forced_grant = 1'b1;
            is_low_bg = 1'b1;
        end else if (i_req.normal_ready) begin
            o_grant.granted_lane = LANE_NORMAL;
            is_high = 1'b1;
        end else if (i_req.compute_ready) begin
            o_grant.granted_lane = LANE_COMPUTE;
            is_high = 1'b1;
        end else if (i_req.background_ready) begin
            o_grant.granted_lane = LANE_BACKGROUND;
            is_low_bg = 1'b1;
        end
    end

    // Counter update according to the kind of grant.
    always_comb begin
        o_burst     = i_burst;
        o_contained = i_contained;
        o_shared    = i_shared;
        if (is_high) begin
            o_burst     = burst_bump;
            o_contained = cont_bump;
            o_shared    = shr_bump;
        end else if (is_low_norm) begin
            o_burst     = '0;
            o_shared    = '0;
            o_contained = cont_bump;
        end else if (is_low_bg) begin
            o_burst     = '0;
            o_contained = '0;
            o_shared    = shr_bump;
        end
    end

endmodule

FILE: rtl/lane_dispatch_starvation_arbiter_core.sv
// Lane dispatch arbiter with starvation guard. Each transaction on the input
// channel is one dispatch request carrying the not-empty flags of five lanes;
// each produces exactly one result transaction with the granted lane (5 when
// nothing is ready) and a flag that marks a grant forced by the starvation
// override. While the output side does not stall, the block takes one request
// per cycle back to back: a request is registered, the grant and the counter
// update are decided from that register and the three saturating counters,
// and the result lands in an output register, so throughput is one transaction
// per cycle. The user must write limits through the configuration port only
// while the block is idle; the block itself does not enforce it.
`include "lane_dispatch_starvation_arbiter_core_macros.svh"

module lane_dispatch_starvation_arbiter_core
    import ldsa_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request channel.
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_req                 i_req,
    // Result channel.
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_grant               o_result,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIMIT_W-1:0]   i_cfg_data
);

    t_limits                r_limits;
    t_req                   r_s1_req;
    logic                   r_s1_valid;
    logic                   r_out_valid;
    t_grant                 r_out;
    logic [COUNT_WIDTH-1:0] r_burst, r_contained, r_shared;
    logic [COUNT_WIDTH-1:0] n_burst, n_contained, n_shared;
    t_grant                 n_out;
    logic                   out_free, s1_adv, in_acc;

    // Handshake: the output register frees up when empty or being taken.
    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign in_acc   = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Limit registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.burst_limit     <= BURST_LIMIT_RST;
            r_limits.contained_limit <= CONTAINED_LIMIT_RST;
            r_limits.shared_limit    <= SHARED_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BURST_LIMIT:     r_limits.burst_limit     <= i_cfg_data;
                CFG_CONTAINED_LIMIT: r_limits.contained_limit <= i_cfg_data;
                CFG_SHARED_LIMIT:    r_limits.shared_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Grant decision and counter update.
    ldsa_grant #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_grant (
        .i_req       (r_s1_req),
        .i_limits    (r_limits),
        .i_burst     (r_burst),
        .i_contained (r_contained),
        .i_shared    (r_shared),
        .o_grant     (n_out),
        .o_burst     (n_burst),
        .o_contained (n_contained),
        .o_shared    (n_shared)
    );

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_req <= i_req;
        end
    end

    // Counters move only when a request passes into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst     <= '0;
            r_contained <= '0;
            r_shared    <= '0;
        end else if (s1_adv) begin
            r_burst     <= n_burst;
            r_contained <= n_contained;
            r_shared    <= n_shared;
        end
    end

    // Result register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    // A forced grant only ever goes to the normal or background lane.
    `LDSA_ASSERT(a_forced_lane, i_clk, i_rst_n,
        (r_out_valid && r_out.forced_grant) |->
            (r_out.granted_lane == LANE_NORMAL || r_out.granted_lane == LANE_BACKGROUND))

    // Counters hold unless a request moves into the result register.
    `LDSA_ASSERT(a_cnt_hold, i_clk, i_rst_n,
        !s1_adv |=> ($stable(r_burst) && $stable(r_contained) && $stable(r_shared)))

    // A background grant clears the burst and contained counters.
    `LDSA_ASSERT(a_bg_clear, i_clk, i_rst_n,
        (s1_adv && n_out.granted_lane == LANE_BACKGROUND) |=>
            (r_burst == '0 && r_contained == '0))

    // No grant leaves the counters untouched.
    `LDSA_ASSERT(a_none_hold, i_clk, i_rst_n,
        (s1_adv && n_out.granted_lane == LANE_NONE) |=>
            ($stable(r_burst) && $stable(r_contained) && $stable(r_shared)))

endmodule
